// ===== rtl/icw_pkg.sv =====
// shared constants, types and codes for the irc colour text to cell writes block
package icw_pkg;

   // grid limits built into the block
   localparam int MAX_COLS = 512;
   localparam int MAX_ROWS = 1024;
   localparam int LIM_W    = 13;

   // field and register widths
   localparam int COLS_REG_W = 10;
   localparam int ROWS_REG_W = 11;
   localparam int CSR_W      = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int COL_CNT_W  = 10;
   localparam int ROW_CNT_W  = 11;
   localparam int COL_W      = 9;
   localparam int ROW_W      = 10;
   localparam int CP_W       = 21;
   localparam int IDX_W      = 7;
   localparam int BYTE_W     = 8;
   localparam int PEND_DEPTH = 3;
   localparam int PEND_IDX_W = 2;
   localparam int ELEN_W     = 3;
   localparam int DIGIT_W    = 2;

   localparam logic [LIM_W-1:0] MAX_COLS_LIM = LIM_W'(MAX_COLS);
   localparam logic [LIM_W-1:0] MAX_ROWS_LIM = LIM_W'(MAX_ROWS);

   // register reset values
   localparam logic [COLS_REG_W-1:0] GRID_COLS_RESET = 10'd80;
   localparam logic [ROWS_REG_W-1:0] GRID_ROWS_RESET = 11'd25;

   // saturation points of the position counters
   localparam logic [COL_CNT_W-1:0] COL_CNT_MAX = '1;
   localparam logic [ROW_CNT_W-1:0] ROW_CNT_MAX = '1;

   // default colours
   localparam logic [IDX_W-1:0] FG_DEFAULT = 7'd1;
   localparam logic [IDX_W-1:0] BG_DEFAULT = 7'd0;

   // character codes seen by the colour parser
   localparam logic [CP_W-1:0] CH_NUL     = CP_W'('h00);
   localparam logic [CP_W-1:0] CH_BOLD    = CP_W'('h02);
   localparam logic [CP_W-1:0] CH_COLOR   = CP_W'('h03);
   localparam logic [CP_W-1:0] CH_LF      = CP_W'('h0A);
   localparam logic [CP_W-1:0] CH_CR      = CP_W'('h0D);
   localparam logic [CP_W-1:0] CH_RESET   = CP_W'('h0F);
   localparam logic [CP_W-1:0] CH_REVERSE = CP_W'('h16);
   localparam logic [CP_W-1:0] CH_ITALIC  = CP_W'('h1D);
   localparam logic [CP_W-1:0] CH_UNDER   = CP_W'('h1F);
   localparam logic [CP_W-1:0] CH_COMMA   = CP_W'('h2C);
   localparam logic [CP_W-1:0] CH_DIGIT0  = CP_W'('h30);
   localparam logic [CP_W-1:0] CH_DIGIT9  = CP_W'('h39);

   // utf-8 sequence lengths
   localparam logic [ELEN_W-1:0] ELEN_NONE  = 3'd0;
   localparam logic [ELEN_W-1:0] ELEN_TWO   = 3'd2;
   localparam logic [ELEN_W-1:0] ELEN_THREE = 3'd3;
   localparam logic [ELEN_W-1:0] ELEN_FOUR  = 3'd4;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_COLS = 1'b0,
      CSR_GRID_ROWS = 1'b1
   } csr_idx_type;

   // colour code parser state
   typedef enum logic [1:0] {
      CODE_PLAIN   = 2'd0,
      CODE_FG      = 2'd1,
      CODE_FG_DONE = 2'd2,
      CODE_BG      = 2'd3
   } code_state_type;

   // byte sequencer state
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_CHECK,
      SEQ_FLUSH,
      SEQ_SCAN,
      SEQ_END
   } seq_state_type;

   // one character handed to the character unit
   typedef struct packed {
      logic            valid;
      logic [CP_W-1:0] ch;
   } feed_type;

   // one cell write
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [CP_W-1:0]  cp;
      logic [IDX_W-1:0] fg;
      logic [IDX_W-1:0] bg;
   } cell_type;

   typedef struct packed {
      logic     valid;
      cell_type wr;
   } emit_type;

endpackage

// ===== rtl/icw_if.sv =====
// request and response channel interfaces
interface icw_req_if import icw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              text_start;

   modport source (output valid, output text_byte, output text_start, input ready);
   modport sink (input valid, input text_byte, input text_start, output ready);
endinterface

interface icw_rsp_if import icw_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [COL_W-1:0] cell_col;
   logic [ROW_W-1:0] cell_row;
   logic [CP_W-1:0]  code_point;
   logic [IDX_W-1:0] fg_index;
   logic [IDX_W-1:0] bg_index;
   logic             run_last;

   modport source (output valid, output cell_col, output cell_row, output code_point,
                   output fg_index, output bg_index, output run_last, input ready);
   modport sink (input valid, input cell_col, input cell_row, input code_point,
                 input fg_index, input bg_index, input run_last, output ready);
endinterface

// ===== rtl/icw_char_unit.sv =====
// shared character unit: colour code parser, grid position and cell write generation
module icw_char_unit import icw_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  feed_type              feed,
   input  logic [COLS_REG_W-1:0] grid_cols,
   input  logic [ROWS_REG_W-1:0] grid_rows,
   output emit_type              emit,
   output logic                  stopped
);

   code_state_type       code_ff, code_in;
   logic [DIGIT_W-1:0]   digit_ff, digit_in;
   logic [IDX_W-1:0]     fg_ff, fg_in;
   logic [IDX_W-1:0]     bg_ff, bg_in;
   logic [COL_CNT_W-1:0] col_ff, col_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;
   logic                 stopped_ff, stopped_in;

   logic                 is_digit;
   logic                 is_format;
   logic                 is_break;
   logic                 in_grid;
   logic                 pass;
   logic [IDX_W-1:0]     acc;
   logic [10:0]          mac_wide;
   logic [IDX_W-1:0]     mac;
   logic [IDX_W-1:0]     digit_val;

   // character classes
   assign is_digit  = feed.ch inside {[CH_DIGIT0:CH_DIGIT9]};
   assign is_format = feed.ch inside {CH_BOLD, CH_ITALIC, CH_UNDER, CH_REVERSE, CH_RESET};
   assign is_break  = feed.ch inside {CH_CR, CH_LF};

   // shared multiply-accumulate for colour digits: acc * 10 + digit
   assign digit_val = IDX_W'(feed.ch[3:0]);
   assign acc       = (code_ff == CODE_BG) ? bg_ff : fg_ff;
   assign mac_wide  = 11'({acc, 3'b000}) + 11'({acc, 1'b0}) + 11'(digit_val);
   assign mac       = mac_wide[IDX_W-1:0];

   // write lands inside the grid
   assign in_grid = (col_ff < grid_cols) && (LIM_W'(col_ff) < MAX_COLS_LIM) &&
                    (row_ff < grid_rows) && (LIM_W'(row_ff) < MAX_ROWS_LIM);

   assign stopped = stopped_ff;

   // next state for one character
   always_comb begin
      code_in    = code_ff;
      digit_in   = digit_ff;
      fg_in      = fg_ff;
      bg_in      = bg_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      stopped_in = stopped_ff;
      pass       = 1'b0;
      emit.valid = 1'b0;
      emit.wr    = '{col: col_ff[COL_W-1:0], row: row_ff[ROW_W-1:0], cp: feed.ch,
                     fg: fg_ff, bg: bg_ff};
      if (clear) begin
         code_in    = CODE_PLAIN;
         digit_in   = '0;
         fg_in      = FG_DEFAULT;
         bg_in      = BG_DEFAULT;
         col_in     = '0;
         row_in     = '0;
         stopped_in = 1'b0;
      end else if (feed.valid && !stopped_ff) begin
         if (feed.ch == CH_NUL) begin
            stopped_in = 1'b1;
         end else if (is_break) begin
            fg_in  = FG_DEFAULT;
            bg_in  = BG_DEFAULT;
            col_in = '0;
            if (feed.ch == CH_LF && row_ff != ROW_CNT_MAX) begin
               row_in = row_ff + 1'b1;
            end
            if (row_in >= grid_rows || LIM_W'(row_in) >= MAX_ROWS_LIM) begin
               stopped_in = 1'b1;
            end
         end else begin
            pass = 1'b1;
            case (code_ff)
               CODE_FG: begin
                  if (is_digit) begin
                     fg_in    = (digit_ff == '0) ? digit_val : mac;
                     digit_in = digit_ff + 1'b1;
                     if (digit_in[1]) begin
                        code_in = CODE_FG_DONE;
                     end
                     pass = 1'b0;
                  end else if (feed.ch == CH_COMMA) begin
                     code_in  = CODE_BG;
                     digit_in = '0;
                     pass     = 1'b0;
                  end else begin
                     code_in = CODE_PLAIN;
                  end
               end
               CODE_FG_DONE: begin
                  if (feed.ch == CH_COMMA) begin
                     code_in  = CODE_BG;
                     digit_in = '0;
                     pass     = 1'b0;
                  end else begin
                     code_in = CODE_PLAIN;
                  end
               end
               CODE_BG: begin
                  if (is_digit) begin
                     bg_in    = (digit_ff == '0) ? digit_val : mac;
                     digit_in = digit_ff + 1'b1;
                     if (digit_in[1]) begin
                        code_in = CODE_PLAIN;
                     end
                     pass = 1'b0;
                  end else begin
                     code_in = CODE_PLAIN;
                  end
               end
               default: begin
               end
            endcase
            // plain handling after the colour code parser lets go
            if (pass) begin
               if (feed.ch == CH_COLOR) begin
                  code_in = CODE_FG;
               end else if (!is_format) begin
                  emit.valid = in_grid;
                  if (col_ff != COL_CNT_MAX) begin
                     col_in = col_ff + 1'b1;
                  end
               end
               digit_in = '0;
            end
         end
      end
   end

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff    <= CODE_PLAIN;
         digit_ff   <= '0;
         fg_ff      <= FG_DEFAULT;
         bg_ff      <= BG_DEFAULT;
         col_ff     <= '0;
         row_ff     <= '0;
         stopped_ff <= 1'b0;
      end else begin
         code_ff    <= code_in;
         digit_ff   <= digit_in;
         fg_ff      <= fg_in;
         bg_ff      <= bg_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         stopped_ff <= stopped_in;
      end
   end

   // at most one digit is held while a colour number is still open
   a_digit_open: assert property (@(posedge clock) disable iff (reset)
      (code_ff == CODE_FG || code_ff == CODE_BG) |-> !digit_ff[1])
      else $error("digit count out of range in open colour number");

   // only a new text releases a stopped parser
   a_stop_holds: assert property (@(posedge clock) disable iff (reset)
      stopped_ff && !clear |=> stopped_ff)
      else $error("parser left stopped state without a new text");

   // a cell write needs a live character
   a_emit_src: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> feed.valid && !stopped_ff && !clear)
      else $error("cell write without a character fed");

endmodule

// ===== rtl/icw_seq.sv =====
// byte sequencer: utf-8 buffering and the order of characters fed to the character unit
module icw_seq import icw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   icw_req_if.sink       req_chan,
   input  logic          stopped,
   input  logic          room,
   output logic          clear,
   output feed_type      feed,
   output logic          close
);

   seq_state_type         state_ff, state_in;
   logic [BYTE_W-1:0]     byte_ff, byte_in;
   logic [BYTE_W-1:0]     pend_ff [PEND_DEPTH];
   logic [BYTE_W-1:0]     pend_in [PEND_DEPTH];
   logic [PEND_IDX_W-1:0] pcnt_ff, pcnt_in;
   logic [ELEN_W-1:0]     elen_ff, elen_in;
   logic [PEND_IDX_W-1:0] idx_ff, idx_in;

   logic                  is_cont;
   logic                  is_lead2;
   logic                  is_lead3;
   logic                  is_lead4;
   logic [CP_W-1:0]       decoded;

   // byte classes
   assign is_cont  = (byte_ff[7:6] == 2'b10);
   assign is_lead2 = (byte_ff[7:5] == 3'b110);
   assign is_lead3 = (byte_ff[7:4] == 4'b1110);
   assign is_lead4 = (byte_ff[7:3] == 5'b11110);

   // assemble the code point from the buffered bytes and the final byte
   always_comb begin
      case (elen_ff)
         ELEN_TWO:   decoded = CP_W'({pend_ff[0][4:0], byte_ff[5:0]});
         ELEN_THREE: decoded = CP_W'({pend_ff[0][3:0], pend_ff[1][5:0], byte_ff[5:0]});
         default:    decoded = CP_W'({pend_ff[0][2:0], pend_ff[1][5:0], pend_ff[2][5:0],
                                      byte_ff[5:0]});
      endcase
   end

   // next state and outputs
   always_comb begin
      state_in          = state_ff;
      byte_in           = byte_ff;
      pend_in           = pend_ff;
      pcnt_in           = pcnt_ff;
      elen_in           = elen_ff;
      idx_in            = idx_ff;
      req_chan.ready    = 1'b0;
      clear             = 1'b0;
      close             = 1'b0;
      feed.valid        = 1'b0;
      feed.ch           = CP_W'(byte_ff);
      case (state_ff)
         SEQ_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               byte_in = req_chan.text_byte;
               if (req_chan.text_start) begin
                  clear   = 1'b1;
                  pcnt_in = '0;
                  elen_in = ELEN_NONE;
               end
               state_in = SEQ_CHECK;
            end
         end
         SEQ_CHECK: begin
            if (stopped) begin
               state_in = SEQ_END;
            end else if (pcnt_ff != '0) begin
               if (is_cont) begin
                  if ((ELEN_W'(pcnt_ff) + 1'b1) >= elen_ff) begin
                     // sequence complete
                     if (room) begin
                        feed.valid = 1'b1;
                        feed.ch    = decoded;
                        pcnt_in    = '0;
                        elen_in    = ELEN_NONE;
                        state_in   = SEQ_END;
                     end
                  end else begin
                     pend_in[pcnt_ff] = byte_ff;
                     pcnt_in          = pcnt_ff + 1'b1;
                     state_in         = SEQ_END;
                  end
               end else begin
                  // broken sequence: replay buffered bytes one by one
                  idx_in   = '0;
                  state_in = SEQ_FLUSH;
               end
            end else begin
               state_in = SEQ_SCAN;
            end
         end
         SEQ_FLUSH: begin
            if (room) begin
               feed.valid = 1'b1;
               feed.ch    = CP_W'(pend_ff[idx_ff]);
               idx_in     = idx_ff + 1'b1;
               if (idx_in == pcnt_ff) begin
                  pcnt_in  = '0;
                  elen_in  = ELEN_NONE;
                  state_in = SEQ_SCAN;
               end
            end
         end
         SEQ_SCAN: begin
            if (stopped) begin
               state_in = SEQ_END;
            end else if (is_lead2 || is_lead3 || is_lead4) begin
               pend_in[0] = byte_ff;
               pcnt_in    = PEND_IDX_W'(1);
               elen_in    = is_lead2 ? ELEN_TWO : (is_lead3 ? ELEN_THREE : ELEN_FOUR);
               state_in   = SEQ_END;
            end else if (room) begin
               feed.valid = 1'b1;
               state_in   = SEQ_END;
            end
         end
         SEQ_END: begin
            if (room) begin
               close    = 1'b1;
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         pcnt_ff  <= '0;
         elen_ff  <= ELEN_NONE;
      end else begin
         state_ff <= state_in;
         pcnt_ff  <= pcnt_in;
         elen_ff  <= elen_in;
      end
   end

   // byte buffer and flush index
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      pend_ff <= pend_in;
      idx_ff  <= idx_in;
   end

endmodule

// ===== rtl/icw_out_stage.sv =====
// result staging: holds the newest cell write until it is known whether it ends its byte
module icw_out_stage import icw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  emit_type      emit,
   input  logic          close,
   output logic          room,
   icw_rsp_if.source     rsp_chan
);

   cell_type res_ff, res_in;
   logic     res_full_ff, res_full_in;
   cell_type out_cell_ff, out_cell_in;
   logic     out_last_ff, out_last_in;
   logic     out_valid_ff, out_valid_in;

   logic     out_free;
   logic     move;

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign room     = !res_full_ff || out_free;
   assign move     = res_full_ff && out_free && (emit.valid || close);

   // hold register and output register updates
   always_comb begin
      res_in       = res_ff;
      res_full_in  = res_full_ff;
      out_cell_in  = out_cell_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      if (move) begin
         out_cell_in  = res_ff;
         out_last_in  = !emit.valid;
         out_valid_in = 1'b1;
         res_full_in  = 1'b0;
      end
      if (emit.valid) begin
         res_in      = emit.wr;
         res_full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_full_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         res_full_ff  <= res_full_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      out_cell_ff <= out_cell_in;
      out_last_ff <= out_last_in;
   end

   // response channel
   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.cell_col   = out_cell_ff.col;
   assign rsp_chan.cell_row   = out_cell_ff.row;
   assign rsp_chan.code_point = out_cell_ff.cp;
   assign rsp_chan.fg_index   = out_cell_ff.fg;
   assign rsp_chan.bg_index   = out_cell_ff.bg;
   assign rsp_chan.run_last   = out_last_ff;

   // a new write never arrives without space for the held one
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> room)
      else $error("cell write arrived with no room");

   // the end of a byte never coincides with a write
   a_close_alone: assert property (@(posedge clock) disable iff (reset)
      !(emit.valid && close))
      else $error("end of byte together with a cell write");

   // closing a byte with a held write sends it out marked last
   a_close_last: assert property (@(posedge clock) disable iff (reset)
      close && res_full_ff |=> out_valid_ff && out_last_ff && !res_full_ff)
      else $error("held write not sent as last of its byte");

endmodule

// ===== rtl/irc_color_text_to_cell_writes_unit.sv =====
// top level of the irc colour text to cell writes block
//
//  channel   direction  transaction
//  req_chan  in         one text byte with its start-of-text flag
//  rsp_chan  out        one cell write: column, row, code point, colours, last flag
//  csr_*     in         register write, index 0 grid_cols, index 1 grid_rows
//
// a byte passes accept, check, scan and close; a buffered or completing continuation
// byte goes from check straight to close, and a broken sequence adds a flush state
// that replays the buffered bytes one per cycle before the scan; the sequencer steps
// one state per cycle unless stalled. reset is synchronous and active high and
// restores 80 columns and 25 rows. a held response stalls the sequencer whenever a
// character is fed or a byte is closed while both result registers are full.
module irc_color_text_to_cell_writes_unit import icw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   icw_req_if.sink              req_chan,
   icw_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  csr_idx_type          csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [COLS_REG_W-1:0] grid_cols_ff, grid_cols_in;
   logic [ROWS_REG_W-1:0] grid_rows_ff, grid_rows_in;

   logic     clear;
   logic     stopped;
   logic     room;
   logic     close;
   feed_type feed;
   emit_type emit;

   // configuration register writes
   always_comb begin
      grid_cols_in = grid_cols_ff;
      grid_rows_in = grid_rows_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GRID_COLS: grid_cols_in = csr_wdata[COLS_REG_W-1:0];
            CSR_GRID_ROWS: grid_rows_in = csr_wdata[ROWS_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= GRID_COLS_RESET;
         grid_rows_ff <= GRID_ROWS_RESET;
      end else begin
         grid_cols_ff <= grid_cols_in;
         grid_rows_ff <= grid_rows_in;
      end
   end

   // byte sequencer
   icw_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .stopped  (stopped),
      .room     (room),
      .clear    (clear),
      .feed     (feed),
      .close    (close)
   );

   // shared character unit
   icw_char_unit u_char_unit (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .feed      (feed),
      .grid_cols (grid_cols_ff),
      .grid_rows (grid_rows_ff),
      .emit      (emit),
      .stopped   (stopped)
   );

   // result staging
   icw_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .emit     (emit),
      .close    (close),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== tb/tb_top.sv =====
// testbench for the irc colour text to cell writes unit: directed texts, random texts, checker
`timescale 1ns / 1ps

module tb_top import icw_pkg::*; ();

   localparam int CYCLE_LIMIT  = 600000;
   localparam int IDLE_CYCLES  = 24;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_BYTES = 335;

   typedef logic [BYTE_W-1:0] text_q_type[$];

   // one expected cell write with its end-of-byte flag
   typedef struct {
      cell_type wr;
      logic     last;
   } grid_write_type;

   logic             clock;
   logic             reset;
   logic             csr_we;
   csr_idx_type      csr_index;
   logic [CSR_W-1:0] csr_wdata;

   icw_req_if req_chan ();
   icw_rsp_if rsp_chan ();

   irc_color_text_to_cell_writes_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // parser state mirrored by the predictor
   logic [BYTE_W-1:0] pend_byte [PEND_DEPTH];
   int unsigned       pend_cnt;
   logic [ELEN_W-1:0] seq_len;
   code_state_type    color_st;
   int unsigned       digits;
   logic [IDX_W-1:0]  fg_now;
   logic [IDX_W-1:0]  bg_now;
   int unsigned       col_now;
   int unsigned       row_now;
   bit                halted;
   int unsigned       cols_cfg;
   int unsigned       rows_cfg;

   grid_write_type byte_writes[$];
   grid_write_type writes_due[$];

   int unsigned fail_count;
   int unsigned cycle_count;
   int unsigned writes_checked;
   int unsigned texts_sent;
   int unsigned bytes_sent;
   int unsigned grids_used;
   bit          src_gaps;
   bit          sink_stalls;
   int          hold_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int unsigned col_limit();
      return (cols_cfg < MAX_COLS) ? cols_cfg : MAX_COLS;
   endfunction

   function automatic int unsigned row_limit();
      return (rows_cfg < MAX_ROWS) ? rows_cfg : MAX_ROWS;
   endfunction

   function automatic void clear_parse();
      foreach (pend_byte[i]) pend_byte[i] = '0;
      pend_cnt = 0;
      seq_len  = ELEN_NONE;
      color_st = CODE_PLAIN;
      digits   = 0;
      fg_now   = FG_DEFAULT;
      bg_now   = BG_DEFAULT;
      col_now  = 0;
      row_now  = 0;
      halted   = 1'b0;
   endfunction

   // one visible character: a write if inside the grid, column moves until it saturates
   function automatic void put_cell(input logic [CP_W-1:0] ch);
      grid_write_type w;
      if (byte_writes.size() < 4 && col_now < col_limit() && row_now < row_limit()) begin
         w.wr.col = COL_W'(col_now);
         w.wr.row = ROW_W'(row_now);
         w.wr.cp  = ch;
         w.wr.fg  = fg_now;
         w.wr.bg  = bg_now;
         w.last   = 1'b0;
         byte_writes.push_back(w);
      end
      if (col_now < 1023) col_now++;
   endfunction

   // colour code parser for one decoded character
   function automatic void take_char(input logic [CP_W-1:0] ch);
      bit is_digit;
      int d;
      is_digit = (ch >= CH_DIGIT0) && (ch <= CH_DIGIT9);
      d = int'(ch) - int'(CH_DIGIT0);
      if (halted) return;
      if (ch == CH_NUL) begin
         halted = 1'b1;
         return;
      end
      // line controls restore colours but keep the code state
      if (ch == CH_CR || ch == CH_LF) begin
         fg_now  = FG_DEFAULT;
         bg_now  = BG_DEFAULT;
         col_now = 0;
         if (ch == CH_LF && row_now < 2047) row_now++;
         if (row_now >= row_limit()) halted = 1'b1;
         return;
      end
      case (color_st)
         CODE_FG: begin
            if (is_digit) begin
               fg_now = (digits == 0) ? IDX_W'(d) : IDX_W'(int'(fg_now) * 10 + d);
               digits = (digits + 1) & 3;
               if (digits >= 2) color_st = CODE_FG_DONE;
               return;
            end
            if (ch == CH_COMMA) begin
               color_st = CODE_BG;
               digits   = 0;
               return;
            end
            color_st = CODE_PLAIN;
         end
         CODE_FG_DONE: begin
            if (ch == CH_COMMA) begin
               color_st = CODE_BG;
               digits   = 0;
               return;
            end
            color_st = CODE_PLAIN;
         end
         CODE_BG: begin
            if (is_digit) begin
               bg_now = (digits == 0) ? IDX_W'(d) : IDX_W'(int'(bg_now) * 10 + d);
               digits = (digits + 1) & 3;
               if (digits >= 2) color_st = CODE_PLAIN;
               return;
            end
            color_st = CODE_PLAIN;
         end
         default: ;
      endcase
      if (ch == CH_COLOR)
         color_st = CODE_FG;
      else if (!(ch == CH_BOLD || ch == CH_ITALIC || ch == CH_UNDER ||
                 ch == CH_REVERSE || ch == CH_RESET))
         put_cell(ch);
      digits = 0;
   endfunction

   // fresh byte: buffer a lead byte, else hand it on as a character
   function automatic void scan_fresh(input logic [BYTE_W-1:0] x);
      if (x == 8'h00) begin
         halted = 1'b1;
      end else if ((x & 8'hE0) == 8'hC0) begin
         pend_byte[0] = x;
         pend_cnt     = 1;
         seq_len      = ELEN_TWO;
      end else if ((x & 8'hF0) == 8'hE0) begin
         pend_byte[0] = x;
         pend_cnt     = 1;
         seq_len      = ELEN_THREE;
      end else if ((x & 8'hF8) == 8'hF0) begin
         pend_byte[0] = x;
         pend_cnt     = 1;
         seq_len      = ELEN_FOUR;
      end else begin
         take_char(CP_W'(x));
      end
   endfunction

   function automatic logic [CP_W-1:0] utf8_value(input logic [BYTE_W-1:0] tail);
      logic [BYTE_W-1:0] a;
      a = pend_byte[0];
      if (seq_len == ELEN_TWO)
         return CP_W'({a[4:0], tail[5:0]});
      if (seq_len == ELEN_THREE)
         return CP_W'({a[3:0], pend_byte[1][5:0], tail[5:0]});
      return {a[2:0], pend_byte[1][5:0], pend_byte[2][5:0], tail[5:0]};
   endfunction

   // accepted text byte: queue the cell writes it causes, returns 0 if ignored
   function automatic bit text_byte_step(input logic [BYTE_W-1:0] x, input logic start);
      int unsigned n;
      grid_write_type w;
      byte_writes.delete();
      if (start) clear_parse();
      if (halted) return 1'b0;
      if (pend_cnt > 0) begin
         if (x[7:6] == 2'b10) begin
            if (pend_cnt + 1 >= seq_len) begin
               w.wr.cp  = utf8_value(x);
               pend_cnt = 0;
               seq_len  = ELEN_NONE;
               take_char(w.wr.cp);
            end else begin
               pend_byte[pend_cnt] = x;
               pend_cnt++;
            end
         end else begin
            // broken sequence: replay buffered bytes, then rescan this one
            n        = pend_cnt;
            pend_cnt = 0;
            seq_len  = ELEN_NONE;
            for (int i = 0; i < n; i++) take_char(CP_W'(pend_byte[i]));
            if (!halted) scan_fresh(x);
         end
      end else begin
         scan_fresh(x);
      end
      foreach (byte_writes[i]) begin
         w      = byte_writes[i];
         w.last = (i == byte_writes.size() - 1);
         writes_due.push_back(w);
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- checker

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // compare each cell write transaction with the oldest expected one
   always @(posedge clock) begin
      grid_write_type w;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (writes_due.size() == 0) begin
            $display("%0t unexpected cell write: col %0d row %0d cp %0h", $time,
                     rsp_chan.cell_col, rsp_chan.cell_row, rsp_chan.code_point);
            fail_count++;
         end else begin
            w = writes_due.pop_front();
            check_field("cell_col", w.wr.col, rsp_chan.cell_col);
            check_field("cell_row", w.wr.row, rsp_chan.cell_row);
            check_field("code_point", w.wr.cp, rsp_chan.code_point);
            check_field("fg_index", w.wr.fg, rsp_chan.fg_index);
            check_field("bg_index", w.wr.bg, rsp_chan.bg_index);
            check_field("run_last", w.last, rsp_chan.run_last);
            writes_checked++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d writes outstanding", cycle_count,
                  writes_due.size());
         $display("FAIL irc_color_text_to_cell_writes_unit");
         $finish;
      end
   end

   // response back-pressure: runs of ready and stalls, mostly short
   always @(negedge clock) begin
      int r;
      if (reset) begin
         rsp_chan.ready <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
      end else if (!sink_stalls) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            rsp_chan.ready <= 1'b1;
            hold_left = $urandom_range(0, 7);
         end else if (r < 90) begin
            rsp_chan.ready <= 1'b0;
            hold_left = $urandom_range(0, 2);
         end else begin
            rsp_chan.ready <= 1'b0;
            hold_left = $urandom_range(8, 30);
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!src_gaps || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one byte transaction, predicted when accepted
   task automatic send_byte(input logic [BYTE_W-1:0] x, input logic start);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_chan.valid      <= 1'b1;
      req_chan.text_byte  <= x;
      req_chan.text_start <= start;
      do @(posedge clock); while (!req_chan.ready);
      void'(text_byte_step(x, start));
      bytes_sent++;
   endtask

   task automatic send_text(input text_q_type t);
      foreach (t[i]) send_byte(t[i], i == 0);
      texts_sent++;
   endtask

   // hold off until every write is back and the sequencer has settled
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (writes_due.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_grid(input int unsigned cols, input int unsigned rows,
                             input bit top_bit);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_GRID_COLS;
      csr_wdata <= {top_bit, cols[COLS_REG_W-1:0]};
      @(negedge clock);
      csr_index <= CSR_GRID_ROWS;
      csr_wdata <= rows[ROWS_REG_W-1:0];
      @(negedge clock);
      csr_we   <= 1'b0;
      cols_cfg = cols & 1023;
      rows_cfg = rows & 2047;
      grids_used++;
   endtask

   function automatic logic [BYTE_W-1:0] cont_byte();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // random text: mostly well-formed tokens, some broken sequences and noise
   function automatic text_q_type make_text();
      text_q_type t;
      int tokens;
      int r;
      int k;
      tokens = $urandom_range(3, 30);
      for (int i = 0; i < tokens; i++) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            t.push_back(8'($urandom_range(8'h20, 8'h7E)));
         end else if (r < 42) begin
            // colour code with optional background part
            t.push_back(8'(CH_COLOR));
            k = $urandom_range(0, 3);
            repeat (k) t.push_back(8'($urandom_range(8'h30, 8'h39)));
            if ($urandom_range(0, 1)) begin
               t.push_back(8'(CH_COMMA));
               k = $urandom_range(0, 3);
               repeat (k) t.push_back(8'($urandom_range(8'h30, 8'h39)));
            end
         end else if (r < 47) begin
            case ($urandom_range(0, 4))
               0: t.push_back(8'(CH_BOLD));
               1: t.push_back(8'(CH_ITALIC));
               2: t.push_back(8'(CH_UNDER));
               3: t.push_back(8'(CH_REVERSE));
               default: t.push_back(8'(CH_RESET));
            endcase
         end else if (r < 55) begin
            t.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            t.push_back(cont_byte());
         end else if (r < 62) begin
            t.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            t.push_back(cont_byte());
            t.push_back(cont_byte());
         end else if (r < 68) begin
            t.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            t.push_back(cont_byte());
            t.push_back(cont_byte());
            t.push_back(cont_byte());
         end else if (r < 76) begin
            // sequence cut short by a non-continuation byte
            case ($urandom_range(0, 2))
               0: t.push_back(8'hC0 | 8'($urandom_range(0, 31)));
               1: t.push_back(8'hE0 | 8'($urandom_range(0, 15)));
               default: t.push_back(8'hF0 | 8'($urandom_range(0, 7)));
            endcase
            k = $urandom_range(0, 2);
            repeat (k) t.push_back(cont_byte());
            if ($urandom_range(0, 1))
               t.push_back(8'($urandom_range(8'h01, 8'h7F)));
            else
               t.push_back(8'($urandom_range(8'hC0, 8'hFF)));
         end else if (r < 81) begin
            if ($urandom_range(0, 1))
               t.push_back(cont_byte());
            else
               t.push_back(8'($urandom_range(8'hF8, 8'hFF)));
         end else if (r < 87) begin
            t.push_back(8'(CH_LF));
         end else if (r < 91) begin
            t.push_back(8'(CH_CR));
         end else begin
            t.push_back(8'($urandom_range(1, 255)));
         end
      end
      if ($urandom_range(0, 1)) t.push_back(8'h00);
      return t;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_plain_and_colors();
      send_text('{8'h48, 8'(CH_BOLD), 8'(CH_ITALIC), 8'(CH_UNDER), 8'(CH_REVERSE),
                  8'(CH_RESET), 8'(CH_COLOR), 8'h37, 8'(CH_COMMA), 8'h39, 8'h39, 8'h61,
                  8'(CH_CR), 8'h62});
   endtask

   task automatic test_utf8();
      // two byte, largest four byte, broken four byte, stray bytes, broken before LF
      send_text('{8'hC3, 8'hA9, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hF0, 8'h9F, 8'h98, 8'h41,
                  8'h80, 8'hFF, 8'hE2, 8'h0A, 8'h00, 8'h7A});
   endtask

   task automatic test_text_end();
      // overlong zero stops the text, later bytes are ignored
      send_text('{8'h71, 8'hC0, 8'h80, 8'h78});
   endtask

   task automatic test_grid_limits();
      write_grid(1, 1, 1'b0);
      send_text('{8'h61, 8'h62, 8'(CH_LF), 8'h63});
      write_grid(0, 0, 1'b0);
      send_text('{8'h61, 8'(CH_CR), 8'h62});
      write_grid(1023, 2047, 1'b1);
      send_text('{8'h61, 8'(CH_LF), 8'h62});
   endtask

   task automatic test_random_texts();
      int unsigned counted;
      int r;
      int unsigned cols;
      int unsigned rows;
      text_q_type t;
      counted = 0;
      while (counted < RANDOM_BYTES) begin
         if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, 99);
            if (r < 5) cols = 0;
            else if (r < 30) cols = $urandom_range(1, 6);
            else if (r < 50) cols = 80;
            else if (r < 60) cols = $urandom_range(511, 512);
            else if (r < 68) cols = 1023;
            else cols = $urandom_range(1, 1023);
            r = $urandom_range(0, 99);
            if (r < 5) rows = 0;
            else if (r < 30) rows = $urandom_range(1, 4);
            else if (r < 55) rows = 25;
            else if (r < 65) rows = 1024;
            else if (r < 73) rows = 2047;
            else rows = $urandom_range(1, 2047);
            write_grid(cols, rows, $urandom_range(0, 4) == 0);
         end
         src_gaps    = $urandom_range(0, 2) != 0;
         sink_stalls = $urandom_range(0, 2) != 0;
         t = make_text();
         foreach (t[i]) begin
            send_byte(t[i], i == 0);
            counted++;
         end
         texts_sent++;
      end
   endtask

   // ---------------------------------------------------------------- main

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_GRID_COLS;
      csr_wdata           = '0;
      req_chan.valid      = 1'b0;
      req_chan.text_byte  = '0;
      req_chan.text_start = 1'b0;
      rsp_chan.ready      = 1'b0;
      hold_left           = 0;
      src_gaps            = 1'b1;
      sink_stalls         = 1'b1;
      fail_count          = 0;
      cycle_count         = 0;
      writes_checked      = 0;
      texts_sent          = 0;
      bytes_sent          = 0;
      grids_used          = 0;
      cols_cfg            = GRID_COLS_RESET;
      rows_cfg            = GRID_ROWS_RESET;
      clear_parse();
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      test_plain_and_colors();
      test_utf8();
      test_text_end();
      test_grid_limits();
      test_random_texts();

      // drain outstanding writes, then watch for strays
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (writes_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d texts, %0d bytes over %0d grid settings", texts_sent, bytes_sent,
               grids_used);
      $display("checked %0d cell writes, %0d mismatches", writes_checked, fail_count);
      if (fail_count == 0)
         $display("PASS irc_color_text_to_cell_writes_unit");
      else
         $display("FAIL irc_color_text_to_cell_writes_unit");
      $finish;
   end

endmodule

// ===== irc_color_text_to_cell_writes_unit.f =====
rtl/icw_pkg.sv
rtl/icw_if.sv
rtl/icw_char_unit.sv
rtl/icw_seq.sv
rtl/icw_out_stage.sv
rtl/irc_color_text_to_cell_writes_unit.sv
tb/tb_top.sv
